// ----- hw/rtl/totp_window_verifier_assert.svh -----
// Assertion macros for the TOTP window verifier sequencer (totp_ctrl).
// No dependencies; define SYNTH to compile the checks out.
`ifndef TOTP_WINDOW_VERIFIER_ASSERT_SVH
`define TOTP_WINDOW_VERIFIER_ASSERT_SVH
`ifndef SYNTH
`define TOTP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("totp assertion failed");
`define TOTP_NEVER(lbl, clk, rstn, expr) \
    `TOTP_ASSERT(lbl, clk, rstn, !(expr))
`else
`define TOTP_ASSERT(lbl, clk, rstn, prop)
`define TOTP_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- hw/rtl/totp_pkg.sv -----
// Shared types, constants and helper functions for the TOTP window verifier.
// No dependencies.
package totp_pkg;

    localparam int KEY_BYTES = 32;

    typedef enum logic [2:0] {
        REG_SECRET0, REG_SECRET1, REG_SECRET2, REG_SECRET3,
        REG_KEY_LEN, REG_DIGITS, REG_STEP, REG_SLACK
    } cfg_idx_t;

    typedef enum logic [1:0] {PH_IPAD, PH_INNER, PH_OPAD, PH_OUTER} phase_t;

    typedef struct packed {
        logic   load;
        logic   div_start;
        logic   cand_init;
        logic   sha_start;
        phase_t phase;
        logic   mod_start;
        logic   score;
        logic   next_cand;
        logic   publish;
    } cmd_t;

    typedef struct packed {
        logic zero_key;
        logic div_done;
        logic sha_done;
        logic mod_done;
        logic last_cand;
        logic out_free;
    } stat_t;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Ten to the power of the digit count, saturating at nine digits
    function automatic logic [29:0] pow10(input logic [3:0] digs);
        logic [29:0] p;
        unique case (digs)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        pow10 = p;
    endfunction

endpackage

// ----- hw/rtl/totp_sha_core.sv -----
// SHA-256 compression, one round per clock over a 16-word schedule window.
// Depends on totp_pkg.
module totp_sha_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] h_in,
    input  logic [511:0] block,
    output logic [255:0] h_out,
    output logic         done
);
    import totp_pkg::*;

    logic [31:0] v_reg [8];
    logic [31:0] hs_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] s1_big, ch, t1, s0_big, maj, t2, ws0, ws1, w_next;

    always_comb
    begin
        s1_big = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + s1_big + ch + SHA_K[rnd_reg] + w_reg[0];
        s0_big = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = s0_big + maj;
        ws0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        ws1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_next = w_reg[0] + ws0 + w_reg[9] + ws1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (rnd_reg == 6'd63);
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int k = 0; k < 8; k++)
            begin
                v_reg[k]  <= h_in[255 - 32*k -: 32];
                hs_reg[k] <= h_in[255 - 32*k -: 32];
            end
            for (int k = 0; k < 16; k++)
                w_reg[k] <= block[511 - 32*k -: 32];
        end
        else if (busy_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int k = 0; k < 15; k++)
                w_reg[k] <= w_reg[k+1];
            w_reg[15] <= w_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
            h_out[255 - 32*k -: 32] = hs_reg[k] + v_reg[k];
    end

    assign done = done_reg;

endmodule

// ----- hw/rtl/totp_serdiv.sv -----
// Restoring divider, one quotient bit per clock.
// No package dependencies.
module totp_serdiv #(
    parameter int DW = 40,
    parameter int VW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem,
    output logic          done
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] num_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, num_reg[DW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CW'(DW);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(trial - {1'b0, den_reg}) : trial[VW-1:0];
        end
    end

    assign quot = num_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/totp_datapath.sv -----
// Datapath: configuration registers, HMAC message assembly, SHA core,
// dividers, candidate scoring and the output register. Depends on totp_pkg, totp_sha_core and totp_serdiv.
module totp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  totp_pkg::cfg_idx_t   cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [39:0]          time_seconds,
    input  logic [31:0]          submitted_code,
    input  logic                 out_stall,
    input  totp_pkg::cmd_t       cmd,
    output totp_pkg::stat_t      stat,
    output logic                 out_valid,
    output logic                 matched,
    output logic signed [41:0]   matched_step,
    output logic [29:0]          centre_code
);
    import totp_pkg::*;

    logic [63:0]  sw_reg [4];
    logic [5:0]   klen_cfg_reg;
    logic [3:0]   digits_cfg_reg;
    logic [11:0]  step_cfg_reg;
    logic [3:0]   slack_cfg_reg;

    logic [31:0]  given_reg;
    logic [39:0]  time_reg;
    logic [255:0] key_reg;
    logic         zero_reg;
    logic [29:0]  modv_reg;
    logic [3:0]   slk_reg;
    logic [11:0]  step_reg;
    logic signed [41:0] cand_reg;
    logic [4:0]   idx_reg;
    logic [255:0] h_reg;
    logic [255:0] inner_reg;
    logic         hit_reg;
    logic signed [41:0] first_reg;
    logic [29:0]  centre_reg;
    logic         out_valid_reg;
    logic         matched_reg;
    logic signed [41:0] mstep_reg;
    logic [29:0]  ccode_reg;

    logic [255:0] key_masked;
    logic [5:0]   klen;
    logic [255:0] sha_h_in;
    logic [511:0] sha_block;
    logic [255:0] sha_h_out;
    logic         sha_done;
    logic [39:0]  div_quot;
    logic [11:0]  div_rem;
    logic         div_done;
    logic [31:0]  trunc_w;
    logic [30:0]  mod_quot;
    logic [29:0]  mod_rem;
    logic         mod_done;
    logic [63:0]  ctr_msg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                sw_reg[k] <= '0;
            klen_cfg_reg   <= 6'd20;
            digits_cfg_reg <= 4'd6;
            step_cfg_reg   <= 12'd30;
            slack_cfg_reg  <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SECRET0: sw_reg[0] <= cfg_data;
                REG_SECRET1: sw_reg[1] <= cfg_data;
                REG_SECRET2: sw_reg[2] <= cfg_data;
                REG_SECRET3: sw_reg[3] <= cfg_data;
                REG_KEY_LEN: klen_cfg_reg   <= cfg_data[5:0];
                REG_DIGITS:  digits_cfg_reg <= cfg_data[3:0];
                REG_STEP:    step_cfg_reg   <= cfg_data[11:0];
                REG_SLACK:   slack_cfg_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clear key bytes beyond the configured length
    always_comb
    begin
        klen = (klen_cfg_reg > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : klen_cfg_reg;
        for (int j = 0; j < 32; j++)
            key_masked[255 - 8*j -: 8] = (6'(j) < klen)
                ? sw_reg[j/8][63 - 8*(j%8) -: 8] : 8'h00;
    end

    assign ctr_msg = {{22{cand_reg[41]}}, cand_reg};

    always_comb
    begin
        case (cmd.phase)
            PH_IPAD:
            begin
                sha_h_in  = SHA_IV;
                sha_block = {key_reg, 256'b0} ^ {64{8'h36}};
            end
            PH_INNER:
            begin
                sha_h_in  = h_reg;
                sha_block = {ctr_msg, 8'h80, 376'b0, 64'd576};
            end
            PH_OPAD:
            begin
                sha_h_in  = SHA_IV;
                sha_block = {key_reg, 256'b0} ^ {64{8'h5c}};
            end
            default:
            begin
                sha_h_in  = h_reg;
                sha_block = {inner_reg, 8'h80, 184'b0, 64'd768};
            end
        endcase
    end

    totp_sha_core u_sha (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sha_start),
        .h_in  (sha_h_in),
        .block (sha_block),
        .h_out (sha_h_out),
        .done  (sha_done)
    );

    totp_serdiv #(.DW(40), .VW(12)) u_stepdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (time_reg),
        .divisor  (step_reg),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    // Dynamic truncation: offset from the low nibble of the last tag byte
    assign trunc_w = h_reg[(255 - {h_reg[3:0], 3'b000}) -: 32];

    totp_serdiv #(.DW(31), .VW(30)) u_moddiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (trunc_w[30:0]),
        .divisor  (modv_reg),
        .quot     (mod_quot),
        .rem      (mod_rem),
        .done     (mod_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            given_reg  <= submitted_code;
            time_reg   <= time_seconds;
            key_reg    <= key_masked;
            modv_reg   <= pow10(digits_cfg_reg);
            slk_reg    <= slack_cfg_reg;
            step_reg   <= (step_cfg_reg == '0) ? 12'd1 : step_cfg_reg;
            zero_reg   <= (klen == '0);
            hit_reg    <= 1'b0;
            first_reg  <= '0;
            centre_reg <= '0;
        end
        if (cmd.cand_init)
        begin
            cand_reg <= $signed({2'b00, div_quot}) - $signed({38'b0, slk_reg});
            idx_reg  <= '0;
        end
        if (sha_done)
        begin
            h_reg <= sha_h_out;
            if (cmd.phase == PH_INNER)
                inner_reg <= sha_h_out;
        end
        if (cmd.score)
        begin
            if (idx_reg == {1'b0, slk_reg})
                centre_reg <= mod_rem;
            if (({2'b00, mod_rem} == given_reg) && !hit_reg)
            begin
                hit_reg   <= 1'b1;
                first_reg <= cand_reg;
            end
        end
        if (cmd.next_cand)
        begin
            cand_reg <= cand_reg + 42'sd1;
            idx_reg  <= idx_reg + 5'd1;
        end
        if (cmd.publish)
        begin
            matched_reg <= hit_reg;
            mstep_reg   <= first_reg;
            ccode_reg   <= centre_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign stat.zero_key  = zero_reg;
    assign stat.div_done  = div_done;
    assign stat.sha_done  = sha_done;
    assign stat.mod_done  = mod_done;
    assign stat.last_cand = (idx_reg == {slk_reg, 1'b0});
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign matched      = matched_reg;
    assign matched_step = mstep_reg;
    assign centre_code  = ccode_reg;

endmodule

// ----- hw/rtl/totp_ctrl.sv -----
// Sequencer: for a non-empty key, steps one item through division, four compressions per
// candidate, reduction, scoring and result transfer. Depends on totp_pkg and totp_window_verifier_assert.svh.
`include "totp_window_verifier_assert.svh"
module totp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  totp_pkg::stat_t  stat,
    output totp_pkg::cmd_t   cmd
);
    import totp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_DIV, ST_SHA_GO, ST_SHA_WAIT, ST_MOD, ST_PUBLISH
    } state_t;

    state_t state_reg;
    phase_t phase_reg;
    cmd_t   cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IPAD;
            cmd_reg   <= '0;
        end
        else
        begin
            cmd_reg       <= '0;
            cmd_reg.phase <= phase_reg;
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid)
                        state_reg <= ST_LOAD;
                ST_LOAD:
                    if (stat.zero_key)
                        state_reg <= ST_PUBLISH;
                    else
                    begin
                        cmd_reg.div_start <= 1'b1;
                        state_reg         <= ST_DIV;
                    end
                ST_DIV:
                    if (stat.div_done)
                    begin
                        cmd_reg.cand_init <= 1'b1;
                        phase_reg         <= PH_IPAD;
                        state_reg         <= ST_SHA_GO;
                    end
                ST_SHA_GO:
                begin
                    cmd_reg.sha_start <= 1'b1;
                    state_reg         <= ST_SHA_WAIT;
                end
                ST_SHA_WAIT:
                    if (stat.sha_done)
                    begin
                        if (phase_reg == PH_OUTER)
                        begin
                            cmd_reg.mod_start <= 1'b1;
                            state_reg         <= ST_MOD;
                        end
                        else
                        begin
                            phase_reg <= phase_t'(phase_reg + 2'd1);
                            state_reg <= ST_SHA_GO;
                        end
                    end
                ST_MOD:
                    if (stat.mod_done)
                    begin
                        cmd_reg.score <= 1'b1;
                        if (stat.last_cand)
                            state_reg <= ST_PUBLISH;
                        else
                        begin
                            cmd_reg.next_cand <= 1'b1;
                            phase_reg         <= PH_IPAD;
                            state_reg         <= ST_SHA_GO;
                        end
                    end
                ST_PUBLISH:
                    if (stat.out_free)
                    begin
                        cmd_reg.publish <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Take the item on the transfer edge itself, the payload may move after
    always_comb
    begin
        cmd      = cmd_reg;
        cmd.load = in_valid && (state_reg == ST_IDLE);
    end

    `TOTP_ASSERT(a_take_loads, clk, rst_n,
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_LOAD))
    `TOTP_ASSERT(a_sha_done_waiting, clk, rst_n,
        stat.sha_done |-> (state_reg == ST_SHA_WAIT))
    `TOTP_ASSERT(a_mod_done_waiting, clk, rst_n,
        stat.mod_done |-> (state_reg == ST_MOD))
    `TOTP_NEVER(a_div_done_stray, clk, rst_n,
        stat.div_done && (state_reg != ST_DIV))

endmodule

// ----- hw/rtl/totp_window_verifier.sv -----
// Top level of the TOTP window verifier (HMAC-SHA256 time-based codes).
// Depends on totp_pkg, totp_ctrl and totp_datapath.
//
// Use: write the key words, key length, digit count, step length and slack
// through the cfg_we / cfg_index / cfg_data port while the block is idle.
// Each input transfer (in_valid high, in_stall low) carries a time in seconds
// and a submitted code; exactly one result transfer follows, carrying the
// match flag, the earliest matching step and the code at the centre step.
// Work: the step division, then per candidate four SHA-256 compressions
// and a modulo reduction, over 2 * slack + 1 candidates; the compression
// unit runs one round per clock. A zero-length key skips the division and
// all hashing and returns a zero result.
// One item is in work at a time; in_stall is low only while idle, and the
// next item can be taken while the previous result still waits.
// A stalled result holds in the output register; a finished item holds
// before transfer until that register is free.
// Reset (rst_n low, asynchronous) drops any item in work, empties the
// output register and restores the register defaults.
module totp_window_verifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  totp_pkg::cfg_idx_t  cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [39:0]         time_seconds,
    input  logic [31:0]         submitted_code,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                matched,
    output logic signed [41:0]  matched_step,
    output logic [29:0]         centre_code
);
    import totp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: issues one command pulse per step of the HMAC schedule
    totp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: register file, hashing, division and result register
    totp_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .time_seconds   (time_seconds),
        .submitted_code (submitted_code),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .matched        (matched),
        .matched_step   (matched_step),
        .centre_code    (centre_code)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for totp_window_verifier: random and directed transfers
// are scored against a behavioural HMAC-SHA256 window predictor.
// Depends on totp_pkg and the totp_window_verifier RTL.

typedef struct packed {
    logic        hit;
    logic [41:0] step;
    logic [29:0] code;
} verdict_t;

class totp_scoreboard;
    logic [63:0] key_word [4];
    logic [5:0]  key_len;
    logic [3:0]  digits;
    logic [11:0] step_len;
    logic [3:0]  slack;
    verdict_t    awaited [$];
    int          errors;

    function new();
        foreach (key_word[i]) key_word[i] = '0;
        key_len  = 6'd20;
        digits   = 4'd6;
        step_len = 12'd30;
        slack    = 4'd1;
        errors   = 0;
    endfunction

    function void write_reg(totp_pkg::cfg_idx_t idx, logic [63:0] v);
        case (idx)
            totp_pkg::REG_SECRET0: key_word[0] = v;
            totp_pkg::REG_SECRET1: key_word[1] = v;
            totp_pkg::REG_SECRET2: key_word[2] = v;
            totp_pkg::REG_SECRET3: key_word[3] = v;
            totp_pkg::REG_KEY_LEN: key_len = v[5:0];
            totp_pkg::REG_DIGITS:  digits = v[3:0];
            totp_pkg::REG_STEP:    step_len = v[11:0];
            totp_pkg::REG_SLACK:   slack = v[3:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function logic [255:0] sha_round_block(logic [255:0] h, logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = h[255 - 32 * i -: 32];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + totp_pkg::SHA_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) h[255 - 32 * i -: 32] += v[i];
        return h;
    endfunction

    function int unsigned active_key_bytes();
        return (key_len > 32) ? 32 : key_len;
    endfunction

    // Code for one step counter under the current key and digit count
    function logic [31:0] code_for_counter(logic [63:0] ctr);
        logic [511:0] keyblk;
        logic [255:0] inner, tag;
        logic [31:0]  trunc, modv;
        int unsigned  klen, ofs, digs;
        klen = active_key_bytes();
        keyblk = '0;
        for (int j = 0; j < klen; j++)
            keyblk[511 - 8 * j -: 8] = key_word[j >> 3][63 - 8 * (j & 7) -: 8];
        inner = sha_round_block(totp_pkg::SHA_IV, keyblk ^ {64{8'h36}});
        inner = sha_round_block(inner, {ctr, 8'h80, 376'b0, 64'd576});
        tag = sha_round_block(totp_pkg::SHA_IV, keyblk ^ {64{8'h5c}});
        tag = sha_round_block(tag, {inner, 8'h80, 184'b0, 64'd768});
        ofs = 32'(tag[3:0]);
        trunc = {1'b0, tag[254 - 8 * ofs -: 31]};
        digs = (digits > 9) ? 9 : digits;
        modv = 1;
        for (int j = 0; j < digs; j++) modv = modv * 10;
        return trunc % modv;
    endfunction

    function logic [63:0] candidate(logic [39:0] t, int unsigned off);
        logic [63:0] mid;
        mid = 64'(t) / 64'((step_len == 0) ? 12'd1 : step_len);
        return mid + 64'(off) - 64'(slack);
    endfunction

    function logic [31:0] code_at(logic [39:0] t, int unsigned off);
        return code_for_counter(candidate(t, off));
    endfunction

    function void note_transfer(logic [39:0] t, logic [31:0] given);
        verdict_t    vd;
        logic [31:0] c;
        vd = '0;
        if (active_key_bytes() != 0)
        begin
            for (int i = 0; i <= 2 * slack; i++)
            begin
                c = code_at(t, i);
                if (i == slack) vd.code = c[29:0];
                if (c == given && !vd.hit)
                begin
                    vd.hit = 1'b1;
                    vd.step = 42'(candidate(t, i));
                end
            end
        end
        awaited.push_back(vd);
    endfunction

    function void check_transfer(logic hit, logic signed [41:0] step, logic [29:0] code);
        verdict_t want;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer");
            return;
        end
        want = awaited.pop_front();
        if (want.hit !== hit || want.step !== step || want.code !== code)
        begin
            errors++;
            if (errors <= 10)
                $display("result: want hit=%0d step=%0d code=%0d, got hit=%0d step=%0d code=%0d",
                         want.hit, $signed(want.step), want.code, hit, step, code);
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 4000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    totp_pkg::cfg_idx_t cfg_index = totp_pkg::REG_SECRET0;
    logic [63:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [39:0]        time_seconds = '0;
    logic [31:0]        submitted_code = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               matched;
    logic signed [41:0] matched_step;
    logic [29:0]        centre_code;

    totp_scoreboard sb = new();
    bit             steady = 1'b0;   // set to suppress idling on both sides
    int             cycles = 0;

    totp_window_verifier dut (.*);

    always #2 clk = ~clk;

    // Watchdog: a hung block must still end the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("totp_window_verifier: mismatch");
            $finish;
        end
    end

    // Result side: score each transfer, then stall at random for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_transfer(matched, matched_step, centre_code);
        out_stall <= !steady && ($urandom_range(99) < 31);
    end

    // Offer one input and hold it until the transfer happens; valid stays high
    // afterwards so that back-to-back items need no second assignment.
    task automatic send_item(logic [39:0] t, logic [31:0] code);
        if (!steady && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        time_seconds <= t;
        submitted_code <= code;
        do @(posedge clk); while (in_stall);
        sb.note_transfer(t, code);
    endtask

    // Drop valid and wait for every outstanding result, plus a short tail
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                             logic [63:0] w3, logic [63:0] klen, logic [63:0] digs,
                             logic [63:0] stp, logic [63:0] slk);
        logic [63:0] vals [8];
        vals = '{w0, w1, w2, w3, klen, digs, stp, slk};
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= totp_pkg::cfg_idx_t'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(totp_pkg::cfg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Times: mostly anywhere, some near zero so candidates go below step zero
    function automatic logic [39:0] pick_time();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 40'($urandom_range(3 * 16 * 4096));
        if (r < 20) return '1;
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Codes: half the time a code from the window so that matches are common
    function automatic logic [31:0] pick_code(logic [39:0] t);
        int unsigned r;
        r = $urandom_range(99);
        if (sb.active_key_bytes() != 0 && r < 50)
            return sb.code_at(t, $urandom_range(2 * sb.slack));
        if (r < 70) return $urandom_range(999999999);
        if (r < 75) return 32'hffffffff;
        return $urandom;
    endfunction

    task automatic random_phase(int unsigned count);
        logic [39:0] t;
        for (int i = 0; i < count; i++)
        begin
            t = pick_time();
            send_item(t, pick_code(t));
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: all-zero 20-byte key, six digits, 30 s, slack one
        send_item(40'd0, sb.code_at(40'd0, 0));        // match below step zero
        send_item(40'd0, 32'd0);
        send_item('1, 32'd0);
        send_item('1, 32'hffffffff);
        send_item('1, sb.code_at('1, 2));
        send_item(40'd12345, sb.code_at(40'd12345, 1));
        send_item(40'd59, sb.code_at(40'd59, 2));
        send_item(40'h5555555555, 32'h55555555);
        send_item(40'haaaaaaaaaa, 32'haaaaaaaa);
        drain();

        // Hold off until every result is back, then offer again
        send_item(40'd1000, sb.code_at(40'd1000, 0));
        drain();
        send_item(40'd1000, sb.code_at(40'd1000, 1));

        // Zero-length key never matches and reports zeros
        drain();
        configure(rand64(), rand64(), rand64(), rand64(), 64'd0, 64'd6, 64'd30, 64'd1);
        send_item(40'd90, 32'd0);
        send_item('1, 32'hffffffff);
        random_phase(40);

        // Full key, nine digits, longest sane step, single candidate
        configure(rand64(), rand64(), rand64(), rand64(), 64'd32, 64'd9, 64'd3600, 64'd0);
        random_phase(120);

        // Oversized length saturates, digits saturate, zero step acts as one
        configure('1, '1, '1, '1, 64'd63, 64'd15, 64'd0, 64'd2);
        send_item(40'd0, sb.code_at(40'd0, 0));
        send_item(40'd1, sb.code_at(40'd1, 1));
        random_phase(100);

        // One-byte key, zero digits: every code is zero
        configure(rand64(), '0, '0, '0, 64'd1, 64'd0, 64'd1, 64'd1);
        send_item(40'd0, 32'd0);
        random_phase(60);

        // Typical settings, half of it with no idling at all
        configure(rand64(), rand64(), rand64(), '0, 64'd20, 64'd6, 64'd30, 64'd1);
        random_phase(100);
        steady = 1'b1;
        random_phase(100);
        steady = 1'b0;

        // Widest window and widest step field
        configure(rand64(), rand64(), rand64(), rand64(), 64'd31, 64'd8, 64'd4095, 64'd15);
        send_item(40'd0, sb.code_at(40'd0, 3));
        random_phase(4);

        // Keys of random length up to 32 bytes, one digit
        configure(rand64(), rand64(), rand64(), rand64(),
                  64'($urandom_range(32, 1)), 64'd1, 64'($urandom_range(4095, 1)), 64'd0);
        random_phase(130);

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("totp_window_verifier: match");
        else
            $display("totp_window_verifier: mismatch");
        $finish;
    end
endmodule
